### src/memory_region_claim_checker_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the memory region claim checker
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef MEMORY_REGION_CLAIM_CHECKER_MACROS_SVH
`define MEMORY_REGION_CLAIM_CHECKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MRC_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRC_ASSERT(label, clk, rst, prop, msg)
`define MRC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### src/mrc_pkg.sv
// ---------------------------------------------------------------------------
// Memory region claim checker package
// Request and status codes, and the overlap and containment functions.
// ---------------------------------------------------------------------------
package mrc_pkg;

   localparam logic [2:0] REQ_WRITE    = 3'd0;
   localparam logic [2:0] REQ_COMMIT   = 3'd1;
   localparam logic [2:0] REQ_CONTAINS = 3'd2;
   localparam logic [2:0] REQ_CLAIM    = 3'd3;
   localparam logic [2:0] REQ_RELEASE  = 3'd4;
   localparam logic [2:0] REQ_LOOKUP   = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_BUSY      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   localparam int unsigned AW = 32;

   typedef logic [AW-1:0] addr_type;

   // Flags a cell raises toward the sequencer at the end of its turn.
   typedef struct packed {
      logic hit_inside;   // range inside this region
      logic hit_kind;     // inside and class matches
      logic hit_point;    // base address lies in this region or starts this claim
      logic clash;        // range overlaps this region or claim
   } cell_flags_type;

   function automatic logic overlaps(addr_type a, addr_type asz, addr_type b, addr_type bsz);
      if (a >= b) begin
         return (a - b) < bsz;
      end
      return (b - a) < asz;
   endfunction

   function automatic logic covers_range(addr_type rs, addr_type rl, addr_type s,
                                         addr_type sz);
      addr_type off;
      off = s - rs;
      return (s >= rs) && (off < rl) && (sz <= rl - off);
   endfunction

endpackage

### src/memory_region_claim_checker.sv
// ---------------------------------------------------------------------------
// Memory region claim checker
// Every request walks the whole row: after the transaction is accepted the
// probe range passes the N cells one cell a cycle, then the S_DONE state
// applies the table update and the S_OUT state offers the result. A commit
// repeats the walk once per entry it checks. The result register holds one
// answer; the next request is taken once it is delivered.
// ---------------------------------------------------------------------------
module memory_region_claim_checker #(
   parameter int N = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type[2:0], base_addr[34:3], range_size[66:35], region_kind[70:67],
   // entry_index[74:71], table_count[79:75], owner[87:80]
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], contained[3], found_kind[7:4]
   output logic [7:0]  rsp_tdata
);
   import mrc_pkg::*;
   `include "memory_region_claim_checker_macros.svh"

   localparam int IW = (N > 1) ? $clog2(N) : 1;
   localparam int CW = $clog2(N + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_DONE = 4'b0100, S_OUT = 4'b1000
   } state_type;

   state_type  state_ff;
   logic [87:0] req_ff;
   logic [CW-1:0] act_ff, outer_ff, step_ff;
   logic [2:0] st_ff;
   logic       cont_ff, any_ff, busy_ff, hit_ff;
   logic [3:0] fk_ff;
   logic [IW-1:0] hidx_ff;

   wire [2:0]  rq   = req_ff[2:0];
   wire addr_type base = req_ff[34:3];
   wire addr_type size = req_ff[66:35];
   wire [3:0]  kind = req_ff[70:67];
   wire [3:0]  eidx = req_ff[74:71];
   wire [4:0]  cnt  = req_ff[79:75];
   wire [7:0]  own  = req_ff[87:80];

   addr_type pst [N+1];
   addr_type psz [N+1];
   logic [3:0] pkd [N+1];
   addr_type rs [N];
   addr_type rl [N];
   logic [3:0] rk [N];
   logic [N-1:0] live, rwe, cwe;
   cell_flags_type rf [N];
   cell_flags_type cf [N];
   logic clr;
   logic [N-1:0] rel_we;

   // Probe injected at the row head: the request itself, or for commit the
   // region being checked against the later ones.
   always_comb begin
      pst[0] = base;
      psz[0] = size;
      pkd[0] = kind;
      if (rq == REQ_COMMIT) begin
         pst[0] = rs[outer_ff[IW-1:0]];
         psz[0] = rl[outer_ff[IW-1:0]];
      end
   end

   genvar g;
   for (g = 0; g < N; g++) begin : g_cell
      mrc_cell u_cell (
         .clock(clock), .reset(reset),
         .pin_start(pst[g]), .pin_size(psz[g]), .pin_kind(pkd[g]),
         .pout_start_ff(pst[g+1]), .pout_size_ff(psz[g+1]), .pout_kind_ff(pkd[g+1]),
         .reg_we(rwe[g]), .wr_start(base), .wr_size(size), .wr_kind(kind),
         .clm_we(cwe[g]), .clm_clear(clr || rel_we[g]), .wr_owner(own),
         .rgn_start(rs[g]), .rgn_size(rl[g]), .reg_kind(rk[g]),
         .clm_live(live[g]), .reg_flags(rf[g]), .clm_flags(cf[g])
      );
   end

   // The probe reaches cell k at step k (step counts from 0 at injection).
   wire [IW-1:0] cur = step_ff[IW-1:0];
   wire in_row  = step_ff < CW'(N);
   wire bad_rng = (base == '0) || (size == '0) || ((base + size) < base);

   logic [N-1:0] free;
   logic [IW-1:0] free_idx;
   logic free_any;
   always_comb begin
      free = ~live;
      free_idx = '0;
      free_any = 1'b0;
      for (int k = N - 1; k >= 0; k--) begin
         if (free[k]) begin
            free_idx = IW'(k);
            free_any = 1'b1;
         end
      end
   end

   logic done_scan;
   always_comb begin
      done_scan = !in_row;
      rwe = '0;
      cwe = '0;
      clr = 1'b0;
      if (state_ff == S_DONE) begin
         if (rq == REQ_WRITE && {1'b0, eidx} < 5'(N)) rwe[eidx[IW-1:0]] = 1'b1;
         if (rq == REQ_COMMIT && st_ff == ST_OK) clr = 1'b1;
         if (rq == REQ_CLAIM && st_ff == ST_OK) cwe[free_idx] = 1'b1;
      end
   end

   logic rel_clear;
   assign rel_clear = (state_ff == S_DONE) && (rq == REQ_RELEASE) && (st_ff == ST_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         act_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               req_ff   <= req_tdata;
               state_ff <= S_SCAN;
               step_ff  <= '0;
               outer_ff <= '0;
               any_ff <= 1'b0; busy_ff <= 1'b0; hit_ff <= 1'b0;
               cont_ff <= 1'b0; fk_ff <= '0; hidx_ff <= '0;
            end
            S_SCAN: begin
               if (in_row) begin
                  if (rq == REQ_COMMIT) begin
                     if (step_ff > outer_ff && step_ff < CW'(cnt) && rf[cur].clash)
                        busy_ff <= 1'b1;
                  end else begin
                     if (step_ff < act_ff) begin
                        if (rf[cur].hit_inside) any_ff <= 1'b1;
                        if (rf[cur].hit_kind) cont_ff <= 1'b1;
                        if (rq == REQ_LOOKUP && rf[cur].hit_point && !hit_ff) begin
                           hit_ff <= 1'b1;
                           fk_ff  <= rk[cur];
                        end
                     end
                     if (rq == REQ_CLAIM && cf[cur].clash) busy_ff <= 1'b1;
                     if (rq == REQ_RELEASE && cf[cur].hit_point && !hit_ff) begin
                        hit_ff  <= 1'b1;
                        hidx_ff <= cur;
                     end
                  end
                  step_ff <= step_ff + 1'b1;
               end
               if (done_scan) begin
                  if (rq == REQ_COMMIT && cnt != 5'd0 && {1'b0, cnt} <= 6'(N)
                      && CW'(outer_ff + 1'b1) < CW'(cnt) && !busy_ff) begin
                     outer_ff <= outer_ff + 1'b1;
                     step_ff  <= '0;
                  end else begin
                     state_ff <= S_DONE;
                     unique case (rq)
                        REQ_WRITE:    st_ff <= ({1'b0, eidx} < 5'(N)) ? ST_OK : ST_INVALID;
                        REQ_COMMIT:   st_ff <= (cnt == 5'd0 || {1'b0, cnt} > 6'(N) || busy_ff)
                                               ? ST_INVALID : ST_OK;
                        REQ_CONTAINS: st_ff <= ST_OK;
                        REQ_CLAIM:    st_ff <= (bad_rng || !any_ff) ? ST_INVALID :
                                               busy_ff ? ST_BUSY :
                                               !free_any ? ST_FULL : ST_OK;
                        REQ_RELEASE:  st_ff <= (base != '0 && hit_ff) ? ST_OK : ST_NOT_FOUND;
                        REQ_LOOKUP:   st_ff <= (base != '0 && hit_ff) ? ST_OK : ST_NOT_FOUND;
                        default:      st_ff <= ST_INVALID;
                     endcase
                     if (rq != REQ_CONTAINS || bad_rng) cont_ff <= 1'b0;
                     if (rq != REQ_LOOKUP || base == '0) fk_ff <= '0;
                  end
               end
            end
            S_DONE: begin
               if (clr) act_ff <= CW'(cnt);
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Release frees the matched claim slot through that cell's clear path.
   always_comb begin
      rel_we = '0;
      if (rel_clear) rel_we[hidx_ff] = 1'b1;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {fk_ff, (cont_ff && st_ff == ST_OK), st_ff};

   `MRC_ASSERT(a_one_out, clock, reset, rsp_tvalid |-> !req_tready, "both sides open")
   `MRC_ASSERT(a_commit, clock, reset, (state_ff == S_DONE && clr) |=> act_ff != '0, "commit left no region")
   `MRC_ASSERT(a_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata), "result changed")
endmodule

### src/mrc_cell.sv
// ---------------------------------------------------------------------------
// Memory region claim checker cell
// Holds one region and one claim entry. A probe range moves through the row
// one cell a cycle; each cell compares it against its own entries.
// ---------------------------------------------------------------------------
module mrc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  mrc_pkg::addr_type    pin_start,
   input  mrc_pkg::addr_type    pin_size,
   input  logic [3:0]           pin_kind,
   output mrc_pkg::addr_type    pout_start_ff,
   output mrc_pkg::addr_type    pout_size_ff,
   output logic [3:0]           pout_kind_ff,
   input  logic                 reg_we,
   input  mrc_pkg::addr_type    wr_start,
   input  mrc_pkg::addr_type    wr_size,
   input  logic [3:0]           wr_kind,
   input  logic                 clm_we,
   input  logic                 clm_clear,
   input  logic [7:0]           wr_owner,
   output mrc_pkg::addr_type    rgn_start,
   output mrc_pkg::addr_type    rgn_size,
   output logic [3:0]           reg_kind,
   output logic                 clm_live,
   output mrc_pkg::cell_flags_type reg_flags,
   output mrc_pkg::cell_flags_type clm_flags
);
   import mrc_pkg::*;

   addr_type   rs_ff, rl_ff, cs_ff, cl_ff;
   logic [3:0] rk_ff;
   logic [7:0] co_ff;

   always_ff @(posedge clock) begin
      pout_start_ff <= pin_start;
      pout_size_ff  <= pin_size;
      pout_kind_ff  <= pin_kind;
      if (reg_we) begin
         rs_ff <= wr_start;
         rl_ff <= wr_size;
         rk_ff <= wr_kind;
      end
      if (reset || clm_clear) begin
         cs_ff <= '0;
         cl_ff <= '0;
         co_ff <= '0;
      end else if (clm_we) begin
         cs_ff <= wr_start;
         cl_ff <= wr_size;
         co_ff <= wr_owner;
      end
   end

   assign rgn_start = rs_ff;
   assign rgn_size  = rl_ff;
   assign reg_kind  = rk_ff;
   assign clm_live  = (cl_ff != '0) && (co_ff == co_ff);

   always_comb begin
      reg_flags.hit_inside = covers_range(rs_ff, rl_ff, pin_start, pin_size);
      reg_flags.hit_kind   = reg_flags.hit_inside && (rk_ff == pin_kind);
      reg_flags.hit_point  = (pin_start >= rs_ff) && ((pin_start - rs_ff) < rl_ff);
      reg_flags.clash      = overlaps(rs_ff, rl_ff, pin_start, pin_size);
      clm_flags.hit_inside = 1'b0;
      clm_flags.hit_kind   = 1'b0;
      clm_flags.hit_point  = (cl_ff != '0) && (cs_ff == pin_start);
      clm_flags.clash      = (cl_ff != '0) && overlaps(pin_start, pin_size, cs_ff, cl_ff);
   end
endmodule

### tb/mrc_response_check.sv
// ---------------------------------------------------------------------------
// Response checker for the memory region claim checker
// Watches both stream channels. For every accepted request it updates its own
// copy of the region and claim tables and queues the expected response. Each
// accepted response is compared field by field against the oldest entry.
// ---------------------------------------------------------------------------
module mrc_response_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [87:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   output int          errors,
   output int          pending
);
   import mrc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REGIONS = 16;
   localparam int CLAIMS  = 16;

   typedef struct packed {
      logic [3:0] found_kind;
      logic       contained;
      logic [2:0] status;
   } answer_type;

   logic [31:0] tbl_start [REGIONS];
   logic [31:0] tbl_length [REGIONS];
   logic [3:0]  tbl_class [REGIONS];
   logic [4:0]  tbl_active;
   logic [31:0] held_start [CLAIMS];
   logic [31:0] held_length [CLAIMS];
   logic [7:0]  held_owner [CLAIMS];
   logic [4:0]  held_count;

   answer_type answers_due[$];

   function automatic logic ranges_cross(logic [31:0] a, logic [31:0] asz,
                                         logic [31:0] b, logic [31:0] bsz);
      logic [31:0] d;
      if (a >= b) begin
         d = a - b;
         return d < bsz;
      end
      d = b - a;
      return d < asz;
   endfunction

   function automatic logic range_wraps(logic [31:0] s, logic [31:0] z);
      logic [31:0] e;
      e = s + z;
      return e < s;
   endfunction

   function automatic logic range_in_region(int r, logic [31:0] s, logic [31:0] z);
      logic [31:0] off;
      if (s < tbl_start[r]) return 1'b0;
      off = s - tbl_start[r];
      return (off < tbl_length[r]) && (z <= tbl_length[r] - off);
   endfunction

   function automatic void clear_claims();
      for (int k = 0; k < CLAIMS; k++) begin
         held_start[k] = '0;
         held_length[k] = '0;
         held_owner[k] = '0;
      end
      held_count = '0;
   endfunction

   // Applies one request to the shadow tables and returns its response.
   function automatic answer_type predict_answer(logic [87:0] d);
      logic [2:0]  op;
      logic [31:0] base, size, off;
      logic [3:0]  kind, idx;
      logic [4:0]  cnt;
      logic [7:0]  who;
      logic        hit, placed;
      answer_type  a;
      op   = d[2:0];
      base = d[34:3];
      size = d[66:35];
      kind = d[70:67];
      idx  = d[74:71];
      cnt  = d[79:75];
      who  = d[87:80];
      a = '0;
      a.status = ST_OK;
      case (op)
         REQ_WRITE: begin
            tbl_start[idx] = base;
            tbl_length[idx] = size;
            tbl_class[idx] = kind;
         end
         REQ_COMMIT: begin
            if (cnt == 0 || cnt > REGIONS) begin
               a.status = ST_INVALID;
            end else begin
               hit = 1'b0;
               for (int i = 0; i < cnt; i++)
                  for (int j = i + 1; j < cnt; j++)
                     if (ranges_cross(tbl_start[i], tbl_length[i],
                                      tbl_start[j], tbl_length[j]))
                        hit = 1'b1;
               if (hit) begin
                  a.status = ST_INVALID;
               end else begin
                  tbl_active = cnt;
                  clear_claims();
               end
            end
         end
         REQ_CONTAINS: begin
            if (base != 0 && size != 0 && !range_wraps(base, size))
               for (int i = 0; i < tbl_active; i++)
                  if (tbl_class[i] == kind && range_in_region(i, base, size))
                     a.contained = 1'b1;
         end
         REQ_CLAIM: begin
            hit = 1'b0;
            if (base != 0 && size != 0 && !range_wraps(base, size))
               for (int i = 0; i < tbl_active; i++)
                  if (range_in_region(i, base, size)) hit = 1'b1;
            if (!hit) begin
               a.status = ST_INVALID;
            end else begin
               for (int i = 0; i < CLAIMS; i++)
                  if (held_length[i] != 0 &&
                      ranges_cross(base, size, held_start[i], held_length[i]))
                     a.status = ST_BUSY;
               if (a.status == ST_OK) begin
                  placed = 1'b0;
                  for (int i = 0; i < CLAIMS; i++)
                     if (!placed && held_length[i] == 0) begin
                        held_start[i] = base;
                        held_length[i] = size;
                        held_owner[i] = who;
                        held_count++;
                        placed = 1'b1;
                     end
                  if (!placed) a.status = ST_FULL;
               end
            end
         end
         REQ_RELEASE: begin
            a.status = ST_NOT_FOUND;
            if (base != 0)
               for (int i = 0; i < CLAIMS; i++)
                  if (a.status == ST_NOT_FOUND && held_length[i] != 0 &&
                      held_start[i] == base) begin
                     held_start[i] = '0;
                     held_length[i] = '0;
                     held_owner[i] = '0;
                     if (held_count > 0) held_count--;
                     a.status = ST_OK;
                  end
         end
         REQ_LOOKUP: begin
            a.status = ST_NOT_FOUND;
            if (base != 0)
               for (int i = 0; i < tbl_active; i++) begin
                  off = base - tbl_start[i];
                  if (a.status == ST_NOT_FOUND && base >= tbl_start[i] &&
                      off < tbl_length[i]) begin
                     a.found_kind = tbl_class[i];
                     a.status = ST_OK;
                  end
               end
         end
         default: a.status = ST_INVALID;
      endcase
      return a;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         tbl_active = '0;
         clear_claims();
         answers_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (answers_due.size() == 0) begin
               $display("%0t: response transaction with nothing outstanding", $realtime);
               errors++;
            end else begin
               want = answers_due.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.contained != want.contained)
                  report_mismatch("contained", got.contained, want.contained);
               if (got.found_kind != want.found_kind)
                  report_mismatch("found_kind", got.found_kind, want.found_kind);
            end
         end
         if (req_tvalid && req_tready)
            answers_due.push_back(predict_answer(req_tdata));
      end
      pending = answers_due.size();
   end
endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// Testbench for the memory region claim checker
// Drives directed and random requests: region table layouts, commits good and
// bad, then claims, releases, contains checks and lookups aimed into the
// committed regions, with random stalls on both channels.
// ---------------------------------------------------------------------------
module testbench;
   import mrc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;
   localparam int TOTAL_ITEMS = 1750;
   localparam int QUIET_ITEMS = 150;
   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_type, base_addr, range_size, region_kind, entry_index, table_count, owner
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // status, contained, found_kind
   logic [7:0]  rsp_tdata;
   int          errors, pending;
   int          sent = 0;
   int          cycles = 0;
   int          stall_left = 0;
   bit          quiet = 1'b0;

   logic [31:0] lay_base [16];
   logic [31:0] lay_size [16];
   logic [3:0]  lay_kind [16];
   int          lay_active = 0;
   logic [31:0] claimed[$];

   memory_region_claim_checker uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   mrc_response_check checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .errors(errors), .pending(pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Response side back-pressure in bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   task automatic send(logic [2:0] op, logic [31:0] base, logic [31:0] size,
                       logic [3:0] kind, logic [3:0] idx, logic [4:0] cnt,
                       logic [7:0] who);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {who, cnt, idx, kind, size, base, op};
      if (op == REQ_WRITE) begin
         lay_base[idx] = base;
         lay_size[idx] = size;
         lay_kind[idx] = kind;
      end
      if (op == REQ_COMMIT && cnt >= 1 && cnt <= 16) lay_active = int'(cnt);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (sent >= TOTAL_ITEMS - QUIET_ITEMS) quiet = 1'b1;
   endtask

   // A fresh table layout: mostly disjoint slices, sometimes empty or clashing.
   task automatic lay_out_regions();
      logic [31:0] b, s;
      for (int i = 0; i < 16; i++) begin
         b = {i[3:0], 28'h0} + $urandom_range(1, 32'h100);
         s = $urandom_range(1, 32'h0800_0000);
         case ($urandom_range(0, 11))
            0: s = '0;
            1: b = $urandom;
            2: s = $urandom;
            default: ;
         endcase
         send(REQ_WRITE, b, s, 4'($urandom_range(0, 15)), i[3:0], 5'($urandom),
              8'($urandom));
      end
   endtask

   task automatic run_operations(int n);
      logic [31:0] b, s;
      int r;
      for (int k = 0; k < n && sent < TOTAL_ITEMS; k++) begin
         r = (lay_active > 0) ? $urandom_range(0, lay_active - 1) : 0;
         b = lay_base[r] + $urandom_range(0, 32'h4000);
         s = $urandom_range(1, 32'h800);
         if ($urandom_range(0, 7) == 0) s = $urandom_range(1, 32'h0800_0000);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: begin
               claimed.push_back(b);
               send(REQ_CLAIM, b, s, 4'($urandom), 4'($urandom), 5'($urandom),
                    8'($urandom));
            end
            7, 8, 9, 10: begin
               if (claimed.size() > 0 && $urandom_range(0, 4) != 0)
                  b = claimed[$urandom_range(0, claimed.size() - 1)];
               send(REQ_RELEASE, b, $urandom, 4'($urandom), 4'($urandom), 5'($urandom),
                    8'($urandom));
            end
            11, 12, 13, 14: begin
               send(REQ_CONTAINS, b, s,
                    ($urandom_range(0, 3) == 0) ? 4'($urandom) : lay_kind[r],
                    4'($urandom), 5'($urandom), 8'($urandom));
            end
            15, 16, 17: send(REQ_LOOKUP, b, $urandom, 4'($urandom), 4'($urandom),
                             5'($urandom), 8'($urandom));
            default: send(3'($urandom), $urandom, $urandom, 4'($urandom), 4'($urandom),
                          5'($urandom), 8'($urandom));
         endcase
      end
   endtask

   initial begin
      logic [4:0] cnt;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(REQ_WRITE, 32'h1000, 32'h1000, 4'd3, 4'd0, 5'd0, 8'd0);
      send(REQ_WRITE, 32'hFFFF_0000, 32'h0000_FFFF, 4'd15, 4'd1, 5'd31, 8'hFF);
      send(REQ_WRITE, 32'h0, 32'h0, 4'd0, 4'd15, 5'd0, 8'd0);
      send(REQ_COMMIT, 32'h0, 32'h0, 4'd0, 4'd0, 5'd0, 8'd0);
      send(REQ_COMMIT, 32'h0, 32'h0, 4'd0, 4'd0, 5'd17, 8'd0);
      send(REQ_COMMIT, 32'h0, 32'h0, 4'd0, 4'd0, 5'd31, 8'd0);
      send(REQ_COMMIT, 32'h0, 32'h0, 4'd0, 4'd0, 5'd2, 8'd0);
      send(REQ_CONTAINS, 32'h0, 32'h10, 4'd3, 4'd0, 5'd0, 8'd0);
      send(REQ_CONTAINS, 32'h1000, 32'h0, 4'd3, 4'd0, 5'd0, 8'd0);
      send(REQ_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 4'd0, 5'd0, 8'd0);
      send(REQ_CONTAINS, 32'hFFFF_0000, 32'h0001_0000, 4'd15, 4'd0, 5'd0, 8'd0);
      send(REQ_CONTAINS, 32'h1000, 32'h1000, 4'd3, 4'd0, 5'd0, 8'd0);
      send(REQ_CONTAINS, 32'h1000, 32'h1000, 4'd4, 4'd0, 5'd0, 8'd0);
      send(REQ_CLAIM, 32'h0, 32'h10, 4'd0, 4'd0, 5'd0, 8'd1);
      send(REQ_CLAIM, 32'h8000, 32'h10, 4'd0, 4'd0, 5'd0, 8'd1);
      send(REQ_CLAIM, 32'h1800, 32'h10, 4'd0, 4'd0, 5'd0, 8'hFF);
      send(REQ_CLAIM, 32'h1808, 32'h10, 4'd0, 4'd0, 5'd0, 8'd2);
      send(REQ_RELEASE, 32'h0, 32'h0, 4'd0, 4'd0, 5'd0, 8'd0);
      send(REQ_RELEASE, 32'h1800, 32'h0, 4'd0, 4'd0, 5'd0, 8'd0);
      send(REQ_RELEASE, 32'h1800, 32'h0, 4'd0, 4'd0, 5'd0, 8'd0);
      send(REQ_LOOKUP, 32'h0, 32'h0, 4'd0, 4'd0, 5'd0, 8'd0);
      send(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd0, 4'd0, 5'd0, 8'd0);
      send(REQ_LOOKUP, 32'h5, 32'h0, 4'd0, 4'd0, 5'd0, 8'd0);
      send(REQ_SPARE_6, 32'h1000, 32'h10, 4'd0, 4'd0, 5'd0, 8'd0);
      send(REQ_SPARE_7, 32'h1000, 32'h10, 4'd0, 4'd0, 5'd0, 8'd0);

      // Every table slot is written before any random commit can read it.
      while (sent < TOTAL_ITEMS) begin
         lay_out_regions();
         cnt = 5'($urandom_range(1, 16));
         if ($urandom_range(0, 5) == 0) cnt = ($urandom_range(0, 1) == 0) ? 5'd0 :
                                              5'($urandom_range(17, 31));
         send(REQ_COMMIT, $urandom, $urandom, 4'($urandom), 4'($urandom), cnt,
              8'($urandom));
         claimed.delete();
         run_operations($urandom_range(20, 80));
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

### memory_region_claim_checker.f
+incdir+src
src/mrc_pkg.sv
src/mrc_cell.sv
src/memory_region_claim_checker.sv
tb/mrc_response_check.sv
tb/testbench.sv
